/* rtl/lfpt_pkg.sv */
`default_nettype none

package lfpt_pkg;

   localparam logic [7:0]  HDR_BYTE = 8'h59;
   localparam logic [15:0] WORD_MAX = 16'hFFFF;

   localparam logic [2:0] CSR_HOLD_ENABLE      = 3'd0;
   localparam logic [2:0] CSR_AMP_MIN_STRENGTH = 3'd1;
   localparam logic [2:0] CSR_MIN_VALID_CM     = 3'd2;
   localparam logic [2:0] CSR_MAX_VALID_CM     = 3'd3;
   localparam logic [2:0] CSR_PLAUSIBLE_MAX_CM = 3'd4;
   localparam logic [2:0] CSR_HOLD_MS          = 3'd5;
   localparam logic [2:0] CSR_STALE_MS         = 3'd6;
   localparam logic [2:0] CSR_WARN_GAP_MS      = 3'd7;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      RES_GOOD   = 2'd0,
      RES_BADSUM = 2'd1,
      RES_REPORT = 2'd2,
      RES_WARN   = 2'd3
   } res_type;

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_BADSUM = 2'd1,
      OP_TICK   = 2'd2,
      OP_REPORT = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [15:0] range_cm;
      logic [15:0] str;
      logic [15:0] tmp;
   } op_type;

   typedef struct packed {
      logic        hold_enable;
      logic [15:0] amp_min_strength;
      logic [15:0] min_valid_cm;
      logic [15:0] max_valid_cm;
      logic [15:0] plausible_max_cm;
      logic [15:0] hold_ms;
      logic [15:0] stale_ms;
      logic [15:0] warn_gap_ms;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/lfpt_front.sv */
`default_nettype none

module lfpt_front
   import lfpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] kind,
   input  wire logic [7:0] data,
   output op_type          op,
   output logic            push
);

   logic [3:0] parse_index_ff, parse_index_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] frame_bytes_ff [2:7];
   logic       fb_we;

   always_comb begin
      parse_index_in = parse_index_ff;
      running_sum_in = running_sum_ff;
      fb_we          = 1'b0;
      push           = 1'b0;
      op.kind        = OP_TICK;
      op.range_cm    = {frame_bytes_ff[3], frame_bytes_ff[2]};
      op.str         = {frame_bytes_ff[5], frame_bytes_ff[4]};
      op.tmp         = {frame_bytes_ff[7], frame_bytes_ff[6]};
      case (kind_type'(kind))
         KIND_BYTE: begin
            if (parse_index_ff == 4'd0) begin
               if (data == HDR_BYTE) begin
                  running_sum_in = data;
                  parse_index_in = 4'd1;
               end
            end else if (parse_index_ff == 4'd1) begin
               if (data != HDR_BYTE) begin
                  parse_index_in = 4'd0;
               end else begin
                  running_sum_in = running_sum_ff + data;
                  parse_index_in = 4'd2;
               end
            end else if (parse_index_ff < 4'd8) begin
               fb_we          = 1'b1;
               running_sum_in = running_sum_ff + data;
               parse_index_in = parse_index_ff + 4'd1;
            end else begin
               parse_index_in = 4'd0;
               push           = 1'b1;
               op.kind        = (running_sum_ff != data) ? OP_BADSUM : OP_FRAME;
            end
         end
         KIND_TICK: begin
            push    = 1'b1;
            op.kind = OP_TICK;
         end
         KIND_REPORT: begin
            push    = 1'b1;
            op.kind = OP_REPORT;
         end
         default: begin
            push = 1'b0;
         end
      endcase
      push = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_index_ff <= 4'd0;
         running_sum_ff <= 8'd0;
      end else if (accept) begin
         parse_index_ff <= parse_index_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && fb_we) begin
         frame_bytes_ff[parse_index_ff[2:0]] <= data;
      end
   end

endmodule

`default_nettype wire

/* rtl/lfpt_queue.sv */
`default_nettype none

module lfpt_queue
   import lfpt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output logic        head_valid,
   output op_type      head_op
);

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

/* rtl/lfpt_back.sv */
`default_nettype none

module lfpt_back
   import lfpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        head_valid,
   input  wire op_type      head_op,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_res,
   output logic [15:0]      rsp_distance_cm,
   output logic             rsp_distance_ok,
   output logic [15:0]      rsp_strength,
   output logic [15:0]      rsp_temperature_raw
);

   logic [31:0] now_ms_ff, now_ms_in;
   logic        have_reading_ff, have_reading_in;
   logic [15:0] current_cm_ff, current_cm_in;
   logic        current_ok_ff, current_ok_in;
   logic [15:0] held_cm_ff, held_cm_in;
   logic        held_ok_ff, held_ok_in;
   logic [31:0] held_time_ff, held_time_in;
   logic [31:0] frame_time_ff, frame_time_in;
   logic [31:0] warn_time_ff, warn_time_in;

   logic        rsp_valid_ff, rsp_valid_in;
   res_type     res_ff, res_in;
   logic [15:0] dist_ff, dist_in;
   logic        ok_ff, ok_in;
   logic [15:0] str_ff, str_in;
   logic [15:0] tmp_ff, tmp_in;
   logic        res_valid;

   logic [31:0] frame_age, warn_age, held_age;
   logic        frame_ok, cur_good, held_good;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = res_ff;
   assign rsp_distance_cm     = dist_ff;
   assign rsp_distance_ok     = ok_ff;
   assign rsp_strength        = str_ff;
   assign rsp_temperature_raw = tmp_ff;

   always_comb begin
      now_ms_in       = now_ms_ff;
      have_reading_in = have_reading_ff;
      current_cm_in   = current_cm_ff;
      current_ok_in   = current_ok_ff;
      held_cm_in      = held_cm_ff;
      held_ok_in      = held_ok_ff;
      held_time_in    = held_time_ff;
      frame_time_in   = frame_time_ff;
      warn_time_in    = warn_time_ff;
      res_valid       = 1'b0;
      res_in          = RES_GOOD;
      dist_in         = 16'd0;
      ok_in           = 1'b0;
      str_in          = 16'd0;
      tmp_in          = 16'd0;

      // ages seen before the tick's increment: now - t
      frame_age = now_ms_ff - frame_time_ff;
      warn_age  = now_ms_ff - warn_time_ff;
      held_age  = now_ms_ff - held_time_ff;

      frame_ok = !(head_op.str < cfg.amp_min_strength || head_op.str == WORD_MAX ||
                   head_op.range_cm == 16'd0 || head_op.range_cm == WORD_MAX);
      cur_good = have_reading_ff && current_ok_ff &&
                 current_cm_ff >= cfg.min_valid_cm && current_cm_ff <= cfg.max_valid_cm;
      held_good = held_ok_ff &&
                  held_cm_ff >= cfg.min_valid_cm && held_cm_ff <= cfg.max_valid_cm &&
                  held_age <= {16'd0, cfg.hold_ms};

      case (head_op.kind)
         OP_FRAME: begin
            current_cm_in   = head_op.range_cm;
            current_ok_in   = frame_ok;
            have_reading_in = 1'b1;
            frame_time_in   = now_ms_ff;
            if (frame_ok && head_op.range_cm >= cfg.min_valid_cm &&
                (!cfg.hold_enable || head_op.range_cm <= cfg.plausible_max_cm)) begin
               held_cm_in   = head_op.range_cm;
               held_ok_in   = 1'b1;
               held_time_in = now_ms_ff;
            end
            res_valid = 1'b1;
            res_in    = RES_GOOD;
            dist_in   = head_op.range_cm;
            ok_in     = frame_ok;
            str_in    = head_op.str;
            tmp_in    = head_op.tmp;
         end
         OP_BADSUM: begin
            res_valid = 1'b1;
            res_in    = RES_BADSUM;
         end
         OP_TICK: begin
            now_ms_in = now_ms_ff + 32'd1;
            if (have_reading_ff && frame_age != '1 &&
                frame_age >= {16'd0, cfg.stale_ms}) begin
               have_reading_in = 1'b0;
               current_ok_in   = 1'b0;
               current_cm_in   = 16'd0;
               if (warn_age != '1 && warn_age >= {16'd0, cfg.warn_gap_ms}) begin
                  warn_time_in = now_ms_in;
                  res_valid    = 1'b1;
                  res_in       = RES_WARN;
               end
            end
         end
         OP_REPORT: begin
            if (cfg.hold_enable) begin
               if (cur_good && current_cm_ff <= cfg.plausible_max_cm) begin
                  res_valid = 1'b1;
                  dist_in   = current_cm_ff;
               end else if (held_good) begin
                  res_valid = 1'b1;
                  dist_in   = held_cm_ff;
               end
            end else if (cur_good) begin
               res_valid = 1'b1;
               dist_in   = current_cm_ff;
            end
            res_in = RES_REPORT;
            ok_in  = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase

      rsp_valid_in = pop ? res_valid : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff       <= 32'd0;
         have_reading_ff <= 1'b0;
         current_cm_ff   <= 16'd0;
         current_ok_ff   <= 1'b0;
         held_cm_ff      <= 16'd0;
         held_ok_ff      <= 1'b0;
         held_time_ff    <= 32'd0;
         frame_time_ff   <= 32'd0;
         warn_time_ff    <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            now_ms_ff       <= now_ms_in;
            have_reading_ff <= have_reading_in;
            current_cm_ff   <= current_cm_in;
            current_ok_ff   <= current_ok_in;
            held_cm_ff      <= held_cm_in;
            held_ok_ff      <= held_ok_in;
            held_time_ff    <= held_time_in;
            frame_time_ff   <= frame_time_in;
            warn_time_ff    <= warn_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         res_ff  <= res_in;
         dist_ff <= dist_in;
         ok_ff   <= ok_in;
         str_ff  <= str_in;
         tmp_ff  <= tmp_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/lidar_frame_parser_tracker.sv */
// Frame parser and range tracker for a serial optical distance sensor.
// Request channel (req_valid / req_stall): one beat per event, req_kind
// selects a received byte (req_data), a one-millisecond tick or a report
// request. Response channel (rsp_valid / rsp_stall): at most one beat per
// request beat, in order: a good frame, a bad checksum, a distance report
// or a timeout warning. Bytes that do not finish a frame, plain ticks and
// unanswered reports give no response beat.
// Configuration: csr_we writes csr_wdata into register csr_index; write
// only while no request beat is in flight.
// Each event goes through the queue to the tracker, whose response is
// registered. Throughput: one request beat per cycle while req_stall is
// low, set by the tracker's state update behind a two-entry queue.
// Reset clears the parser, tracker state, queue and response valid bit;
// registers return to their defaults. No clearing pass is needed.
// A stalled response holds; the queue absorbs two more queued events, then
// req_stall rises until the response is taken.
`default_nettype none

module lidar_frame_parser_tracker
   import lfpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_res,
   output logic [15:0]      rsp_distance_cm,
   output logic             rsp_distance_ok,
   output logic [15:0]      rsp_strength,
   output logic [15:0]      rsp_temperature_raw,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   op_type  front_op, head_op;
   logic    accept, push, full, pop, head_valid;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_enable      <= 1'b0;
         cfg_ff.amp_min_strength <= 16'd100;
         cfg_ff.min_valid_cm     <= 16'd2;
         cfg_ff.max_valid_cm     <= 16'd1000;
         cfg_ff.plausible_max_cm <= 16'd400;
         cfg_ff.hold_ms          <= 16'd2000;
         cfg_ff.stale_ms         <= 16'd600;
         cfg_ff.warn_gap_ms      <= 16'd30000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOLD_ENABLE:      cfg_ff.hold_enable      <= csr_wdata[0];
            CSR_AMP_MIN_STRENGTH: cfg_ff.amp_min_strength <= csr_wdata;
            CSR_MIN_VALID_CM:     cfg_ff.min_valid_cm     <= csr_wdata;
            CSR_MAX_VALID_CM:     cfg_ff.max_valid_cm     <= csr_wdata;
            CSR_PLAUSIBLE_MAX_CM: cfg_ff.plausible_max_cm <= csr_wdata;
            CSR_HOLD_MS:          cfg_ff.hold_ms          <= csr_wdata;
            CSR_STALE_MS:         cfg_ff.stale_ms         <= csr_wdata;
            CSR_WARN_GAP_MS:      cfg_ff.warn_gap_ms      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lfpt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .data   (req_data),
      .op     (front_op),
      .push   (push)
   );

   lfpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (front_op),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   lfpt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head_valid          (head_valid),
      .head_op             (head_op),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_distance_cm     (rsp_distance_cm),
      .rsp_distance_ok     (rsp_distance_ok),
      .rsp_strength        (rsp_strength),
      .rsp_temperature_raw (rsp_temperature_raw)
   );

endmodule

`default_nettype wire

/* rtl/lfpt_checker.sv */
`default_nettype none

module lfpt_checker
   import lfpt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_event_res,
   input wire logic [15:0] rsp_distance_cm,
   input wire logic        rsp_distance_ok,
   input wire logic [15:0] rsp_strength,
   input wire logic [15:0] rsp_temperature_raw
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) &&
      $stable(rsp_distance_cm) && $stable(rsp_distance_ok) &&
      $stable(rsp_strength) && $stable(rsp_temperature_raw))
      else $error("stalled response changed");

   a_badsum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == RES_BADSUM |->
      rsp_distance_cm == 16'd0 && !rsp_distance_ok &&
      rsp_strength == 16'd0 && rsp_temperature_raw == 16'd0)
      else $error("bad checksum beat carries data");

   a_warn_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == RES_WARN |->
      rsp_distance_cm == 16'd0 && !rsp_distance_ok &&
      rsp_strength == 16'd0 && rsp_temperature_raw == 16'd0)
      else $error("warning beat carries data");

   a_report_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == RES_REPORT |->
      rsp_distance_ok && rsp_distance_cm != 16'd0 &&
      rsp_strength == 16'd0 && rsp_temperature_raw == 16'd0)
      else $error("malformed report beat");

   // no response beat straight after reset; a response needs a request beat taken earlier
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind lidar_frame_parser_tracker lfpt_checker u_lfpt_checker (.*);

`default_nettype wire
